// File: src/sha1_pkg.sv
// sha1_pkg: shared types, constants and round functions for the SHA-1 hasher.
// No dependencies; used by sha1_sched, sha1_round and sha1_stream_hasher.
`timescale 1ns / 1ps

package sha1_pkg;

  localparam int NumWords  = 5;
  localparam int NumRounds = 80;
  localparam int RndW      = 7;
  localparam int IdxW      = 3;
  localparam int PosW      = 6;
  localparam int LenW      = 64;

  localparam logic              OP_ABSORB = 1'b0;
  localparam logic              OP_FINISH = 1'b1;
  localparam logic [7:0]        PAD_BYTE  = 8'h80;
  localparam logic [PosW-1:0]   LEN_POS   = 6'd56;
  localparam logic [IdxW-1:0]   LAST_IDX  = 3'd4;
  localparam logic [RndW-1:0]   LAST_RND  = 7'(NumRounds - 1);

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sha1_state_t;

  typedef logic [NumWords-1:0][31:0] sha1_words_t;

  // schedule window control
  typedef struct packed {
    logic       load_byte;
    logic [7:0] data;
    logic       step;
  } sha1_sched_ctrl_t;

  // round unit control
  typedef struct packed {
    logic            load;
    logic            step;
    logic [RndW-1:0] rnd;
  } sha1_round_ctrl_t;

  function automatic logic [31:0] h_init(input logic [IdxW-1:0] i);
    logic [31:0] v;
    case (i)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      default: v = 32'hC3D2E1F0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [RndW-1:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20)      k = K0;
    else if (rnd < 7'd40) k = K1;
    else if (rnd < 7'd60) k = K2;
    else                  k = K3;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [RndW-1:0] rnd,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20)      f = (b & c) | (~b & d);
    else if (rnd < 7'd40) f = b ^ c ^ d;
    else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                  f = b ^ c ^ d;
    return f;
  endfunction

endpackage

// File: src/sha1_sched.sv
// sha1_sched: 512-bit block register; takes bytes in during loading and acts
// as the sliding 16-word message schedule during rounds. Uses sha1_pkg.
`timescale 1ns / 1ps

module sha1_sched (
  input  logic                      clk,
  input  sha1_pkg::sha1_sched_ctrl_t ctrl,
  output logic [31:0]               w_cur
);

  localparam int BlkW = 512;

  logic [BlkW-1:0] blk_r;
  logic [BlkW-1:0] blk_nxt;
  logic [31:0]     w_new;
  logic [31:0]     w_mix;

  // word i of the window sits at blk_r[BlkW-1-32*i -: 32]
  assign w_cur = blk_r[BlkW-1 -: 32];
  assign w_mix = blk_r[BlkW-1-32*13 -: 32] ^ blk_r[BlkW-1-32*8 -: 32] ^
                 blk_r[BlkW-1-32*2 -: 32] ^ blk_r[BlkW-1 -: 32];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    blk_nxt = blk_r;
    if (ctrl.load_byte) begin
      blk_nxt = {blk_r[BlkW-9:0], ctrl.data};
    end else if (ctrl.step) begin
      blk_nxt = {blk_r[BlkW-33:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

// File: src/sha1_round.sv
// sha1_round: working variables a..e and the shared round datapath, one
// round per step. Uses sha1_pkg for round constants and functions.
`timescale 1ns / 1ps

module sha1_round (
  input  logic                       clk,
  input  sha1_pkg::sha1_round_ctrl_t ctrl,
  input  sha1_pkg::sha1_words_t      h_vals,
  input  logic [31:0]                w_cur,
  output sha1_pkg::sha1_words_t      vars
);

  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] tmp;

  assign tmp = {a_r[26:0], a_r[31:27]} +
               sha1_pkg::round_f(ctrl.rnd, b_r, c_r, d_r) + e_r + w_cur +
               sha1_pkg::round_k(ctrl.rnd);

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    if (ctrl.load) begin
      a_nxt = h_vals[0];
      b_nxt = h_vals[1];
      c_nxt = h_vals[2];
      d_nxt = h_vals[3];
      e_nxt = h_vals[4];
    end else if (ctrl.step) begin
      a_nxt = tmp;
      b_nxt = a_r;
      c_nxt = {b_r[1:0], b_r[31:2]};
      d_nxt = c_r;
      e_nxt = d_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
  end

  assign vars[0] = a_r;
  assign vars[1] = b_r;
  assign vars[2] = c_r;
  assign vars[3] = d_r;
  assign vars[4] = e_r;

endmodule

// File: src/sha1_stream_hasher.sv
// sha1_stream_hasher: top level of the streaming SHA-1 engine.
// Instantiates sha1_sched and sha1_round; uses sha1_pkg.
`timescale 1ns / 1ps

// SHA-1 over a byte stream. An absorb item (operation 0) takes one byte in
// while the engine is idle; the 64th byte of a block starts the compression,
// which runs 80 rounds on one shared round unit (one round per cycle) and
// then folds a..e into the chaining words in ST_ADD. A finish item
// (operation 1) feeds the padding bytes through the same byte path one per
// cycle (0x80, zeros, the 64-bit big-endian bit length), then compresses;
// when fewer than 8 bytes are left after the 0x80 an extra block is padded
// and compressed first. The five digest words then come out on the result
// channel, word 0 first, last_word set on word 4, one per cycle when not
// stalled. After the fifth word the engine is back at the initial chaining
// value with zero length. in_stall is high from an accepted item until its
// work is done (and, on finish, until all five words have been taken).

module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_message_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha1_pkg::sha1_state_t state_r, state_nxt;

  logic [sha1_pkg::PosW-1:0] pos_r, pos_nxt;       // next byte slot
  logic [sha1_pkg::LenW-1:0] bitlen_r, bitlen_nxt; // message bits, mod 2^64
  logic [sha1_pkg::RndW-1:0] rnd_r, rnd_nxt;
  logic [sha1_pkg::IdxW-1:0] idx_r, idx_nxt;       // digest word on output
  logic                      fin_r, fin_nxt;       // finish in progress
  logic                      last_r, last_nxt;     // current block is final
  logic                      first_r, first_nxt;   // next pad byte is 0x80
  sha1_pkg::sha1_words_t     h_r, h_nxt;

  sha1_pkg::sha1_sched_ctrl_t sctl;
  sha1_pkg::sha1_round_ctrl_t rctl;
  sha1_pkg::sha1_words_t      vars;
  logic [31:0]                w_cur;
  logic [7:0]                 len_byte;
  logic                       out_take;

  sha1_sched u_sched (
    .clk   (clk),
    .ctrl  (sctl),
    .w_cur (w_cur)
  );

  sha1_round u_round (
    .clk    (clk),
    .ctrl   (rctl),
    .h_vals (h_r),
    .w_cur  (w_cur),
    .vars   (vars)
  );

  // length byte k of 8 goes into slot 56 + k, most significant first
  assign len_byte = 8'(bitlen_r >> {~pos_r[2:0], 3'b000});
  assign out_take = out_valid && !out_stall;

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    bitlen_nxt = bitlen_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    fin_nxt    = fin_r;
    last_nxt   = last_r;
    first_nxt  = first_r;
    h_nxt      = h_r;
    sctl       = '0;
    rctl       = '0;
    rctl.rnd   = rnd_r;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == sha1_pkg::OP_ABSORB) begin
            sctl.load_byte = 1'b1;
            sctl.data      = in_message_byte;
            pos_nxt        = pos_r + sha1_pkg::PosW'(1);
            bitlen_nxt     = bitlen_r + 64'd8;
            fin_nxt        = 1'b0;
            if (&pos_r) begin
              rctl.load = 1'b1;
              state_nxt = sha1_pkg::ST_ROUND;
            end
          end else begin
            fin_nxt   = 1'b1;
            first_nxt = 1'b1;
            state_nxt = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        sctl.load_byte = 1'b1;
        if (first_r) begin
          sctl.data = sha1_pkg::PAD_BYTE;
          // room for the length after the 0x80 means this block is final
          last_nxt  = (pos_r < sha1_pkg::LEN_POS);
          first_nxt = 1'b0;
        end else if (last_r && pos_r >= sha1_pkg::LEN_POS) begin
          sctl.data = len_byte;
        end else begin
          sctl.data = 8'h00;
        end
        pos_nxt = pos_r + sha1_pkg::PosW'(1);
        if (&pos_r) begin
          rctl.load = 1'b1;
          state_nxt = sha1_pkg::ST_ROUND;
        end
      end
      sha1_pkg::ST_ROUND: begin
        sctl.step = 1'b1;
        rctl.step = 1'b1;
        rnd_nxt   = rnd_r + sha1_pkg::RndW'(1);
        if (rnd_r == sha1_pkg::LAST_RND) begin
          rnd_nxt   = '0;
          state_nxt = sha1_pkg::ST_ADD;
        end
      end
      sha1_pkg::ST_ADD: begin
        for (int i = 0; i < sha1_pkg::NumWords; i++) begin
          h_nxt[i] = h_r[i] + vars[i];
        end
        if (!fin_r) begin
          state_nxt = sha1_pkg::ST_IDLE;
        end else if (!last_r) begin
          // extra padding block holds the length
          last_nxt  = 1'b1;
          state_nxt = sha1_pkg::ST_PAD;
        end else begin
          idx_nxt   = '0;
          state_nxt = sha1_pkg::ST_OUT;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + sha1_pkg::IdxW'(1);
          if (idx_r == sha1_pkg::LAST_IDX) begin
            idx_nxt    = '0;
            pos_nxt    = '0;
            bitlen_nxt = '0;
            fin_nxt    = 1'b0;
            last_nxt   = 1'b0;
            for (int i = 0; i < sha1_pkg::NumWords; i++) begin
              h_nxt[i] = sha1_pkg::h_init(sha1_pkg::IdxW'(i));
            end
            state_nxt = sha1_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sha1_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sha1_pkg::ST_IDLE;
      pos_r    <= '0;
      bitlen_r <= '0;
      rnd_r    <= '0;
      idx_r    <= '0;
      fin_r    <= 1'b0;
      last_r   <= 1'b0;
      first_r  <= 1'b0;
      for (int i = 0; i < sha1_pkg::NumWords; i++) begin
        h_r[i] <= sha1_pkg::h_init(sha1_pkg::IdxW'(i));
      end
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      bitlen_r <= bitlen_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
      fin_r    <= fin_nxt;
      last_r   <= last_nxt;
      first_r  <= first_nxt;
      h_r      <= h_nxt;
    end
  end

  assign in_stall        = (state_r != sha1_pkg::ST_IDLE);
  assign out_valid       = (state_r == sha1_pkg::ST_OUT);
  assign out_digest_word = h_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == sha1_pkg::LAST_IDX);

  // a compression always starts on a block boundary
  a_round_on_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1_pkg::ST_ROUND) |-> (pos_r == '0))
    else $error("round running with a partial block");

  // round counter is clear outside the rounds
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sha1_pkg::ST_ROUND) |-> (rnd_r == '0))
    else $error("round counter not clear outside compression");

  // digest words only while finishing, never past word 4
  a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (fin_r && last_r && idx_r <= sha1_pkg::LAST_IDX))
    else $error("digest output out of sequence");

  // after the last word the engine is back at its initial state
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && out_last_word) |=>
      (state_r == sha1_pkg::ST_IDLE && bitlen_r == '0 && pos_r == '0 &&
       h_r[0] == sha1_pkg::h_init(3'd0)))
    else $error("state not restored after digest");

endmodule
